### rtl/core/cbll_pkg.sv
package cbll_pkg;

	localparam int NUM_CLASSES = 4;
	localparam int SLOT_W      = 6;

	typedef logic [7:0]        age_t;
	typedef logic [15:0]       tag_t;
	typedef logic [1:0]        class_t;
	typedef logic [2:0]        status_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [1:0]        reg_idx_t;
	typedef logic              req_kind_t;

	localparam req_kind_t REQ_INSERT = 1'b0;
	localparam req_kind_t REQ_QUERY  = 1'b1;

	localparam status_t ST_INSERTED  = 3'd0;
	localparam status_t ST_MEMBER    = 3'd1;
	localparam status_t ST_EMPTY     = 3'd2;
	localparam status_t ST_BAD_RANGE = 3'd3;
	localparam status_t ST_FULL      = 3'd4;

	localparam reg_idx_t REG_BOUND_FIRST  = 2'd0;
	localparam reg_idx_t REG_BOUND_SECOND = 2'd1;
	localparam reg_idx_t REG_BOUND_THIRD  = 2'd2;

	localparam age_t BOUND_FIRST_RST  = 8'd5;
	localparam age_t BOUND_SECOND_RST = 8'd10;
	localparam age_t BOUND_THIRD_RST  = 8'd18;

	typedef struct packed {
		age_t first;
		age_t second;
		age_t third;
	} bounds_t;

	typedef struct packed {
		logic   ok;
		class_t cls;
	} cls_res_t;

	typedef struct packed {
		status_t status;
		class_t  cls;
		slot_t   slot;
		tag_t    tag;
		age_t    age;
		logic    last;
	} rsp_t;

endpackage

### rtl/core/cbll_if.sv
interface cbll_req_if;
	logic               valid;
	logic               ready;
	cbll_pkg::req_kind_t req_type;
	cbll_pkg::age_t     age;
	cbll_pkg::tag_t     record_tag;
	cbll_pkg::age_t     range_low;
	cbll_pkg::age_t     range_high;

	modport source (output valid, output req_type, output age, output record_tag,
		output range_low, output range_high, input ready);
	modport sink (input valid, input req_type, input age, input record_tag,
		input range_low, input range_high, output ready);
endinterface

interface cbll_rsp_if;
	logic               valid;
	logic               ready;
	cbll_pkg::status_t  status;
	cbll_pkg::class_t   class_index;
	cbll_pkg::slot_t    slot;
	cbll_pkg::tag_t     out_tag;
	cbll_pkg::age_t     out_age;
	logic               last;

	modport source (output valid, output status, output class_index, output slot,
		output out_tag, output out_age, output last, input ready);
	modport sink (input valid, input status, input class_index, input slot,
		input out_tag, input out_age, input last, output ready);
endinterface

### rtl/core/cbll_classify.sv
module cbll_classify (
	input  logic               is_query,
	input  cbll_pkg::age_t     age,
	input  cbll_pkg::age_t     range_low,
	input  cbll_pkg::age_t     range_high,
	input  cbll_pkg::bounds_t  bounds,
	output cbll_pkg::cls_res_t res
);
	import cbll_pkg::*;

	always_comb begin
		res.ok  = 1'b1;
		res.cls = 2'd0;
		if (!is_query) begin
			if (age <= bounds.first) begin
				res.cls = 2'd0;
			end else if (age <= bounds.second) begin
				res.cls = 2'd1;
			end else if (age <= bounds.third) begin
				res.cls = 2'd2;
			end else begin
				res.cls = 2'd3;
			end
		end else begin
			if (range_high <= bounds.first) begin
				res.cls = 2'd0;
			end else if (range_low > bounds.first && range_high <= bounds.second) begin
				res.cls = 2'd1;
			end else if (range_low > bounds.second && range_high <= bounds.third) begin
				res.cls = 2'd2;
			end else if (range_low > bounds.third && range_high >= range_low) begin
				res.cls = 2'd3;
			end else begin
				res.ok = 1'b0;
			end
		end
	end

endmodule

### rtl/core/cbll_store.sv
module cbll_store #(
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic           clk,
	input  logic           rec_we,
	input  logic [AW-1:0]  wr_addr,
	input  cbll_pkg::age_t wr_age,
	input  cbll_pkg::tag_t wr_tag,
	input  logic           lnk_we,
	input  logic [AW-1:0]  lnk_addr,
	input  logic [AW-1:0]  lnk_data,
	input  logic           rd_en,
	input  logic [AW-1:0]  rd_addr,
	output cbll_pkg::age_t rd_age,
	output cbll_pkg::tag_t rd_tag,
	output logic [AW-1:0]  rd_link
);
	import cbll_pkg::*;

	age_t        age_mem  [DEPTH];
	tag_t        tag_mem  [DEPTH];
	logic [AW-1:0] link_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (rec_we) begin
			age_mem[wr_addr] <= wr_age;
			tag_mem[wr_addr] <= wr_tag;
		end
		if (lnk_we) begin
			link_mem[lnk_addr] <= lnk_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_age  <= age_mem[rd_addr];
			rd_tag  <= tag_mem[rd_addr];
			rd_link <= link_mem[rd_addr];
		end
	end

endmodule

### rtl/core/class_bucketed_linked_lists_core.sv
// Record store with four class lists, selected by three age bounds.
// Channel req: a request is an insert (age, record_tag) or a query
// (range_low, range_high). Channel rsp: result items; last marks the final
// result of a request. cfg_we/cfg_index/cfg_data write the three bounds. The user
// must write them only while no request is in progress; the block does not check.
// Sequence: a request is taken while the sequencer is idle. A status result
// is loaded into the output register from S_EXEC, the first member of a query
// from S_EMIT after the store read; ready rises again once the request is done.
// In a query, the single read port of the record store delivers one member
// per cycle while the output register is not stalled by rsp.ready.
// Stall: the output register holds its result while rsp.ready is low and the
// sequencer waits; req.ready stays low until the request is finished.
// Reset: all lists empty, store count zero, bounds 5, 10 and 18. The store
// memories are not cleared; only linked entries are ever read.
module class_bucketed_linked_lists_core #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	cbll_req_if.sink           req,
	cbll_rsp_if.source         rsp,
	input  logic               cfg_we,
	input  cbll_pkg::reg_idx_t cfg_index,
	input  cbll_pkg::age_t     cfg_data
);
	import cbll_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t        state_q, state_d;
	bounds_t       bounds_q;
	req_kind_t     req_type_q;
	age_t          age_q, lo_q, hi_q;
	tag_t          tag_q;
	logic [CW-1:0] fill_q;
	logic [AW-1:0] head_q [NUM_CLASSES];
	logic [AW-1:0] tail_q [NUM_CLASSES];
	logic [NUM_CLASSES-1:0] cv_q;
	logic [AW-1:0] cur_q;
	class_t        ccls_q;
	rsp_t          rsp_q, out_d;
	logic          ovalid_q;

	cls_res_t      cres;
	logic          out_free, out_load, full, rec_we, lnk_we, rd_en;
	logic [AW-1:0] fill_idx, rd_addr;
	age_t          rd_age;
	tag_t          rd_tag;
	logic [AW-1:0] rd_link;

	cbll_classify u_classify (
		.is_query   (req_type_q == REQ_QUERY),
		.age        (age_q),
		.range_low  (lo_q),
		.range_high (hi_q),
		.bounds     (bounds_q),
		.res        (cres)
	);

	cbll_store #(.DEPTH(CAPACITY)) u_store (
		.clk      (clk),
		.rec_we   (rec_we),
		.wr_addr  (fill_idx),
		.wr_age   (age_q),
		.wr_tag   (tag_q),
		.lnk_we   (lnk_we),
		.lnk_addr (tail_q[cres.cls]),
		.lnk_data (fill_idx),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_age   (rd_age),
		.rd_tag   (rd_tag),
		.rd_link  (rd_link)
	);

	assign fill_idx = fill_q[AW-1:0];
	assign full     = (fill_q == CW'(CAPACITY));
	assign out_free = !ovalid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);

	assign rsp.valid       = ovalid_q;
	assign rsp.status      = rsp_q.status;
	assign rsp.class_index = rsp_q.cls;
	assign rsp.slot        = rsp_q.slot;
	assign rsp.out_tag     = rsp_q.tag;
	assign rsp.out_age     = rsp_q.age;
	assign rsp.last        = rsp_q.last;

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		out_d    = '0;
		rec_we   = 1'b0;
		lnk_we   = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = head_q[cres.cls];
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					out_d.last = 1'b1;
					if (req_type_q == REQ_INSERT) begin
						out_load  = 1'b1;
						out_d.cls = cres.cls;
						state_d   = S_IDLE;
						if (full) begin
							out_d.status = ST_FULL;
						end else begin
							out_d.status = ST_INSERTED;
							out_d.slot   = SLOT_W'(fill_idx);
							out_d.tag    = tag_q;
							out_d.age    = age_q;
							rec_we       = 1'b1;
							lnk_we       = cv_q[cres.cls];
						end
					end else if (!cres.ok) begin
						out_load     = 1'b1;
						out_d.status = ST_BAD_RANGE;
						state_d      = S_IDLE;
					end else if (!cv_q[cres.cls]) begin
						out_load     = 1'b1;
						out_d.status = ST_EMPTY;
						out_d.cls    = cres.cls;
						state_d      = S_IDLE;
					end else begin
						rd_en   = 1'b1;
						state_d = S_EMIT;
					end
				end
			end
			S_EMIT: begin
				rd_addr = rd_link;
				if (out_free) begin
					out_load     = 1'b1;
					out_d.status = ST_MEMBER;
					out_d.cls    = ccls_q;
					out_d.slot   = SLOT_W'(cur_q);
					out_d.tag    = rd_tag;
					out_d.age    = rd_age;
					out_d.last   = (cur_q == tail_q[ccls_q]);
					if (out_d.last) begin
						state_d = S_IDLE;
					end else begin
						rd_en = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			cv_q     <= '0;
			ovalid_q <= 1'b0;
			bounds_q <= '{first: BOUND_FIRST_RST, second: BOUND_SECOND_RST,
				third: BOUND_THIRD_RST};
		end else begin
			state_q <= state_d;
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			if (rec_we) begin
				fill_q         <= fill_q + 1'b1;
				cv_q[cres.cls] <= 1'b1;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BOUND_FIRST:  bounds_q.first  <= cfg_data;
					REG_BOUND_SECOND: bounds_q.second <= cfg_data;
					REG_BOUND_THIRD:  bounds_q.third  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_q <= req.req_type;
			age_q      <= req.age;
			tag_q      <= req.record_tag;
			lo_q       <= req.range_low;
			hi_q       <= req.range_high;
		end
		if (out_load) begin
			rsp_q <= out_d;
		end
		if (rec_we) begin
			if (!cv_q[cres.cls]) begin
				head_q[cres.cls] <= fill_idx;
			end
			tail_q[cres.cls] <= fill_idx;
		end
		if (rd_en) begin
			cur_q <= rd_addr;
		end
		if (state_q == S_EXEC) begin
			ccls_q <= cres.cls;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(CAPACITY))
		else $error("store count beyond capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> CW'(cur_q) < fill_q)
		else $error("list walk reached an unwritten slot");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_d.status == ST_INSERTED) |=> fill_q == $past(fill_q) + 1'b1)
		else $error("insert result without store count advance");

	for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_chk
		assert property (@(posedge clk) disable iff (!arst_n)
			cv_q[c] |-> head_q[c] <= tail_q[c])
			else $error("class head beyond its tail");
	end

endmodule

### tb/class_bucketed_linked_lists_core_tb.sv
`timescale 1ns / 1ps

module class_bucketed_linked_lists_core_tb;
	import cbll_pkg::*;

	localparam int CAP = 64;
	localparam logic [6:0] NO_LINK = 7'd64;
	localparam int LIMIT = 1000000;

	typedef struct {
		req_kind_t kind;
		age_t      age;
		tag_t      tag;
		age_t      lo;
		age_t      hi;
	} request_t;

	logic     clk;
	logic     arst_n;
	logic     cfg_we;
	reg_idx_t cfg_index;
	age_t     cfg_data;

	cbll_req_if req_bus ();
	cbll_rsp_if rsp_bus ();

	class_bucketed_linked_lists_core #(.CAPACITY(CAP)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_bus),
		.rsp       (rsp_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	age_t       shadow_age [CAP];
	tag_t       shadow_tag [CAP];
	logic [6:0] shadow_next [CAP];
	logic [6:0] shadow_head [NUM_CLASSES];
	logic [6:0] shadow_tail [NUM_CLASSES];
	int         shadow_fill;
	bounds_t    shadow_bounds;

	request_t request_backlog [$];
	rsp_t     due_results [$];
	request_t on_bus;
	rsp_t     got, want;
	int       send_idle_pct;
	int       rcv_idle_pct;
	int       mismatch_count;
	int       cycle_count;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic forecast_request(input request_t r);
		class_t     c;
		rsp_t       e;
		logic [6:0] p;
		int         n;
		e = '0;
		e.last = 1'b1;
		if (r.kind == REQ_INSERT) begin
			if (r.age <= shadow_bounds.first)
				c = 2'd0;
			else if (r.age <= shadow_bounds.second)
				c = 2'd1;
			else if (r.age <= shadow_bounds.third)
				c = 2'd2;
			else
				c = 2'd3;
			e.cls = c;
			if (shadow_fill >= CAP) begin
				e.status = ST_FULL;
			end else begin
				e.status = ST_INSERTED;
				e.slot = slot_t'(shadow_fill);
				e.tag = r.tag;
				e.age = r.age;
				shadow_age[shadow_fill] = r.age;
				shadow_tag[shadow_fill] = r.tag;
				shadow_next[shadow_fill] = NO_LINK;
				if (shadow_tail[c] < NO_LINK)
					shadow_next[shadow_tail[c]] = 7'(shadow_fill);
				else
					shadow_head[c] = 7'(shadow_fill);
				shadow_tail[c] = 7'(shadow_fill);
				shadow_fill++;
			end
			due_results.push_back(e);
			return;
		end
		if (r.hi <= shadow_bounds.first)
			c = 2'd0;
		else if (r.lo > shadow_bounds.first && r.hi <= shadow_bounds.second)
			c = 2'd1;
		else if (r.lo > shadow_bounds.second && r.hi <= shadow_bounds.third)
			c = 2'd2;
		else if (r.lo > shadow_bounds.third && r.hi >= r.lo)
			c = 2'd3;
		else begin
			e.status = ST_BAD_RANGE;
			due_results.push_back(e);
			return;
		end
		e.cls = c;
		p = shadow_head[c];
		if (p >= NO_LINK) begin
			e.status = ST_EMPTY;
			due_results.push_back(e);
			return;
		end
		n = 0;
		while (p < NO_LINK && n < CAP) begin
			e.status = ST_MEMBER;
			e.slot = p[SLOT_W-1:0];
			e.tag = shadow_tag[p];
			e.age = shadow_age[p];
			n++;
			e.last = (shadow_next[p] >= NO_LINK) || (n >= CAP);
			due_results.push_back(e);
			p = shadow_next[p];
		end
	endtask

	task automatic report_mismatch(input string what, input rsp_t g, input rsp_t w);
		mismatch_count++;
		if (mismatch_count <= 40) begin
			$write("%0t %s: got st=%0d cls=%0d slot=%0d tag=%h age=%0d last=%0b, ",
				$time, what, g.status, g.cls, g.slot, g.tag, g.age, g.last);
			$display("want st=%0d cls=%0d slot=%0d tag=%h age=%0d last=%0b",
				w.status, w.cls, w.slot, w.tag, w.age, w.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
		end else if (!req_bus.valid || req_bus.ready) begin
			if (req_bus.valid)
				forecast_request(on_bus);
			if (request_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				on_bus = request_backlog.pop_front();
				req_bus.valid <= 1'b1;
				req_bus.req_type <= on_bus.kind;
				req_bus.age <= on_bus.age;
				req_bus.record_tag <= on_bus.tag;
				req_bus.range_low <= on_bus.lo;
				req_bus.range_high <= on_bus.hi;
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
		end else begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				got.status = rsp_bus.status;
				got.cls = rsp_bus.class_index;
				got.slot = rsp_bus.slot;
				got.tag = rsp_bus.out_tag;
				got.age = rsp_bus.out_age;
				got.last = rsp_bus.last;
				if (due_results.size() == 0) begin
					report_mismatch("unexpected result", got, '0);
				end else begin
					want = due_results.pop_front();
					if (got.status !== want.status || got.cls !== want.cls
						|| got.slot !== want.slot || got.tag !== want.tag
						|| got.age !== want.age || got.last !== want.last)
						report_mismatch("result mismatch", got, want);
				end
			end
			rsp_bus.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic queue_request(input req_kind_t k, input age_t a, input tag_t t,
		input age_t lo, input age_t hi);
		request_t r;
		r.kind = k;
		r.age = a;
		r.tag = t;
		r.lo = lo;
		r.hi = hi;
		request_backlog.push_back(r);
	endtask

	task automatic drain();
		@(negedge clk);
		while (request_backlog.size() != 0 || req_bus.valid || due_results.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_bound(input reg_idx_t idx, input age_t val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_BOUND_FIRST:  shadow_bounds.first = val;
			REG_BOUND_SECOND: shadow_bounds.second = val;
			default:          shadow_bounds.third = val;
		endcase
	endtask

	task automatic run_phase(input int f, input int s, input int t, input int snd,
		input int rcv, input int count, input int insert_pct);
		int       i;
		int       target;
		int       lo;
		int       hi;
		int       a;
		age_t     pick;
		write_bound(REG_BOUND_FIRST, age_t'(f));
		write_bound(REG_BOUND_SECOND, age_t'(s));
		write_bound(REG_BOUND_THIRD, age_t'(t));
		@(posedge clk);
		cfg_we <= 1'b0;
		send_idle_pct <= snd;
		rcv_idle_pct <= rcv;
		for (i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < insert_pct) begin
				a = $urandom_range(0, 255);
				if ($urandom_range(0, 3) == 0) begin
					case ($urandom_range(0, 2))
						0: pick = age_t'(f);
						1: pick = age_t'(s);
						default: pick = age_t'(t);
					endcase
					a = pick + $urandom_range(0, 1);
				end
				queue_request(REQ_INSERT, age_t'(a), tag_t'($urandom_range(0, 65535)),
					age_t'($urandom_range(0, 255)), age_t'($urandom_range(0, 255)));
			end else begin
				target = $urandom_range(0, 4);
				lo = $urandom_range(0, 255);
				hi = $urandom_range(0, 255);
				if (target == 0) begin
					hi = $urandom_range(0, f);
				end else if (target == 1 && f < s) begin
					lo = $urandom_range(f + 1, s);
					hi = $urandom_range(lo, s);
				end else if (target == 2 && s < t) begin
					lo = $urandom_range(s + 1, t);
					hi = $urandom_range(lo, t);
				end else if (target == 3 && t < 255) begin
					lo = $urandom_range(t + 1, 255);
					hi = $urandom_range(lo, 255);
				end
				queue_request(REQ_QUERY, age_t'($urandom_range(0, 255)),
					tag_t'($urandom_range(0, 65535)), age_t'(lo), age_t'(hi));
			end
		end
		drain();
	endtask

	initial begin
		int f;
		int s;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_BOUND_FIRST;
		cfg_data = '0;
		req_bus.valid = 1'b0;
		req_bus.req_type = REQ_INSERT;
		req_bus.age = '0;
		req_bus.record_tag = '0;
		req_bus.range_low = '0;
		req_bus.range_high = '0;
		rsp_bus.ready = 1'b0;
		send_idle_pct = 10;
		rcv_idle_pct = 88;
		mismatch_count = 0;
		cycle_count = 0;
		shadow_fill = 0;
		shadow_bounds.first = BOUND_FIRST_RST;
		shadow_bounds.second = BOUND_SECOND_RST;
		shadow_bounds.third = BOUND_THIRD_RST;
		for (int k = 0; k < NUM_CLASSES; k++) begin
			shadow_head[k] = NO_LINK;
			shadow_tail[k] = NO_LINK;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty class, invalid range, records on both sides of each bound, then queries
		queue_request(REQ_QUERY, 8'd0, 16'h0000, 8'd0, 8'd0);
		queue_request(REQ_QUERY, 8'hff, 16'hffff, 8'd3, 8'd8);
		queue_request(REQ_INSERT, 8'd0, 16'h0000, 8'hff, 8'hff);
		queue_request(REQ_INSERT, 8'd255, 16'hffff, 8'd0, 8'd0);
		queue_request(REQ_INSERT, 8'd5, 16'h1234, 8'd0, 8'd0);
		queue_request(REQ_INSERT, 8'd6, 16'h5a5a, 8'd0, 8'd0);
		queue_request(REQ_INSERT, 8'd10, 16'ha5a5, 8'd0, 8'd0);
		queue_request(REQ_INSERT, 8'd11, 16'h00ff, 8'd0, 8'd0);
		queue_request(REQ_INSERT, 8'd18, 16'hff00, 8'd0, 8'd0);
		queue_request(REQ_INSERT, 8'd19, 16'h8001, 8'd0, 8'd0);
		queue_request(REQ_QUERY, 8'd0, 16'h0000, 8'd200, 8'd3);
		queue_request(REQ_QUERY, 8'd0, 16'h0000, 8'd6, 8'd10);
		queue_request(REQ_QUERY, 8'd0, 16'h0000, 8'd11, 8'd18);
		queue_request(REQ_QUERY, 8'd0, 16'h0000, 8'd19, 8'd255);
		queue_request(REQ_QUERY, 8'd0, 16'h0000, 8'd255, 8'd255);
		queue_request(REQ_QUERY, 8'd0, 16'h0000, 8'd200, 8'd100);
		queue_request(REQ_QUERY, 8'd0, 16'h0000, 8'd255, 8'd0);
		queue_request(REQ_QUERY, 8'd0, 16'h0000, 8'd0, 8'd5);
		drain();

		run_phase(0, 0, 0, 10, 88, 62, 60);
		run_phase(255, 255, 255, 10, 88, 62, 50);
		run_phase(40, 100, 200, 88, 10, 62, 30);
		run_phase(200, 50, 100, 88, 10, 62, 30);
		run_phase($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
			0, 0, 62, 30);
		f = $urandom_range(0, 80);
		s = $urandom_range(f, 170);
		run_phase(f, s, $urandom_range(s, 255), 0, 0, 62, 30);

		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && due_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
